// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the multi-queue linked-list core.
// Expects signals named clk and rst in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_SYNC(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- rtl/mqll_pkg.sv -----
// Types and codes of the multi-queue linked-list core.
// No dependencies; the controller, datapath and top module import this package.
package mqll_pkg;

  // Operation codes of a request
  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_PUSH = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_NULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_TAIL_LINK,
    S_LINK_RD,
    S_RESULT
  } state_t;

  // Source of the data written into the head memory
  typedef enum logic [1:0] {
    HEAD_SRC_ZERO,
    HEAD_SRC_ITEM,
    HEAD_SRC_LINK
  } head_src_t;

  // Address of a link memory write
  typedef enum logic [1:0] {
    LINK_ADDR_TAIL,
    LINK_ADDR_ITEM,
    LINK_ADDR_HEAD
  } link_addr_t;

  // Source of the data written into the link memory
  typedef enum logic [1:0] {
    LINK_SRC_ZERO,
    LINK_SRC_ITEM,
    LINK_SRC_HEAD
  } link_src_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       capture;
    logic       clr_step;
    logic       head_we;
    head_src_t  head_src;
    logic       tail_we;
    logic       link_we;
    link_addr_t link_addr;
    link_src_t  link_src;
    logic       link_rd;
    logic       res_load;
    logic [1:0] res_status;
    logic       res_from_head;
    logic       out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [1:0] op;
    logic       item_bad;
    logic       list_bad;
    logic       head_empty;
    logic       tail_ok;
    logic       clr_last;
    logic       out_busy;
  } dp_status_t;

endpackage

// ----- rtl/mqll_req_if.sv -----
// Request channel of the multi-queue linked-list core: valid/ready and payload.
// No dependencies.
interface mqll_req_if #(
  parameter int ITEM_W = 10,
  parameter int LIST_W = 6
) ();
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [ITEM_W-1:0] item_in;
  logic [LIST_W-1:0] list_sel;

  modport source (output valid, output op, output item_in, output list_sel, input ready);
  modport sink   (input valid, input op, input item_in, input list_sel, output ready);
endinterface

// ----- rtl/mqll_rsp_if.sv -----
// Response channel of the multi-queue linked-list core: valid/ready and payload.
// No dependencies.
interface mqll_rsp_if #(
  parameter int ITEM_W = 10
) ();
  logic              valid;
  logic              ready;
  logic [ITEM_W-1:0] item_out;
  logic [1:0]        status;

  modport source (output valid, output item_out, output status, input ready);
  modport sink   (input valid, input item_out, input status, output ready);
endinterface

// ----- rtl/mqll_ctrl.sv -----
// Controller state machine of the multi-queue linked-list core.
// Depends on mqll_pkg and assert_macros.svh; drives the datapath commands.
`include "assert_macros.svh"

module mqll_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  mqll_pkg::dp_status_t   sts,
  output mqll_pkg::ctrl_cmd_t    cmd
);
  import mqll_pkg::*;

  state_t state;
  state_t state_next;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        state_next = S_RESULT;
        if (sts.op == OP_ENQ && !sts.item_bad && !sts.list_bad) begin
          state_next = S_TAIL_LINK;
        end else if (sts.op == OP_DEQ && !sts.list_bad && !sts.head_empty) begin
          state_next = S_LINK_RD;
        end
      end
      S_TAIL_LINK: state_next = S_RESULT;
      S_LINK_RD:   state_next = S_RESULT;
      S_RESULT: begin
        if (!sts.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Commands
  always_comb begin
    cmd           = '0;
    cmd.head_src  = HEAD_SRC_ZERO;
    cmd.link_addr = LINK_ADDR_ITEM;
    cmd.link_src  = LINK_SRC_ZERO;
    in_ready      = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_LOOKUP: begin
        case (sts.op)
          OP_ENQ: begin
            if (sts.item_bad || sts.list_bad) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = STATUS_NULL;
            end else begin
              // Empty list takes the item as head, else a valid old tail links to it
              cmd.head_we   = sts.head_empty;
              cmd.head_src  = HEAD_SRC_ITEM;
              cmd.link_we   = !sts.head_empty && sts.tail_ok;
              cmd.link_addr = LINK_ADDR_TAIL;
              cmd.link_src  = LINK_SRC_ITEM;
              cmd.tail_we   = 1'b1;
            end
          end
          OP_PUSH: begin
            cmd.res_load = 1'b1;
            if (sts.item_bad || sts.list_bad) begin
              cmd.res_status = STATUS_NULL;
            end else begin
              cmd.res_status = STATUS_DONE;
              cmd.tail_we    = sts.head_empty;
              cmd.link_we    = 1'b1;
              cmd.link_addr  = LINK_ADDR_ITEM;
              cmd.link_src   = LINK_SRC_HEAD;
              cmd.head_we    = 1'b1;
              cmd.head_src   = HEAD_SRC_ITEM;
            end
          end
          OP_DEQ: begin
            if (sts.list_bad || sts.head_empty) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = STATUS_EMPTY;
            end else begin
              cmd.link_rd = 1'b1;
            end
          end
          default: begin
            cmd.res_load   = 1'b1;
            cmd.res_status = STATUS_DONE;
          end
        endcase
      end
      S_TAIL_LINK: begin
        // Terminate the new tail
        cmd.link_we    = 1'b1;
        cmd.link_addr  = LINK_ADDR_ITEM;
        cmd.link_src   = LINK_SRC_ZERO;
        cmd.res_load   = 1'b1;
        cmd.res_status = STATUS_DONE;
      end
      S_LINK_RD: begin
        // Advance the head to its successor and detach the removed item
        cmd.head_we       = 1'b1;
        cmd.head_src      = HEAD_SRC_LINK;
        cmd.link_we       = 1'b1;
        cmd.link_addr     = LINK_ADDR_HEAD;
        cmd.link_src      = LINK_SRC_ZERO;
        cmd.res_load      = 1'b1;
        cmd.res_status    = STATUS_DONE;
        cmd.res_from_head = 1'b1;
      end
      S_RESULT: begin
        cmd.out_load = !sts.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `ASSERT_SYNC(a_lookup_after_idle, state == S_LOOKUP |-> $past(state) == S_IDLE, "lookup not entered from idle")
  `ASSERT_SYNC(a_clear_ends, (state == S_CLEAR && sts.clr_last) |=> state == S_IDLE, "clearing pass did not end")

endmodule

// ----- rtl/mqll_datapath.sv -----
// Datapath of the multi-queue linked-list core: head, tail and link memories,
// request and result registers. Depends on mqll_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mqll_datapath #(
  parameter int NUM_ITEMS = 1023,
  parameter int NUM_LISTS = 63
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mqll_pkg::ctrl_cmd_t               cmd,
  output mqll_pkg::dp_status_t              sts,
  input  logic [1:0]                        op,
  input  logic [$clog2(NUM_ITEMS+1)-1:0]    item_in,
  input  logic [$clog2(NUM_LISTS+1)-1:0]    list_sel,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [$clog2(NUM_ITEMS+1)-1:0]    item_out,
  output logic [1:0]                        status
);
  import mqll_pkg::*;

  localparam int ITEM_W     = $clog2(NUM_ITEMS + 1);
  localparam int LIST_W     = $clog2(NUM_LISTS + 1);
  localparam int ITEM_DEPTH = NUM_ITEMS + 1;
  localparam int LIST_DEPTH = NUM_LISTS + 1;
  localparam logic [ITEM_W-1:0] MAX_ITEM = ITEM_W'(NUM_ITEMS);
  localparam logic [LIST_W-1:0] MAX_LIST = LIST_W'(NUM_LISTS);

  logic [ITEM_W-1:0] link_mem [ITEM_DEPTH];
  logic [ITEM_W-1:0] head_mem [LIST_DEPTH];
  logic [ITEM_W-1:0] tail_mem [LIST_DEPTH];

  logic [1:0]        op_q;
  logic [ITEM_W-1:0] item_q;
  logic [LIST_W-1:0] list_q;
  logic [ITEM_W-1:0] head_rd;
  logic [ITEM_W-1:0] tail_rd;
  logic [ITEM_W-1:0] link_rd;
  logic [LIST_W-1:0] clr_cnt;
  logic [ITEM_W-1:0] res_item;
  logic [1:0]        res_status;

  logic              head_wen;
  logic [LIST_W-1:0] head_waddr;
  logic [ITEM_W-1:0] head_wdata;
  logic [ITEM_W-1:0] link_waddr;
  logic [ITEM_W-1:0] link_wdata;

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= op;
      item_q <= item_in;
      list_q <= list_sel;
    end
  end

  // Step the clearing pass over the head memory
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Select head write address and data
  always_comb begin
    head_wen   = cmd.head_we || cmd.clr_step;
    head_waddr = cmd.clr_step ? clr_cnt : list_q;
    case (cmd.head_src)
      HEAD_SRC_ITEM: head_wdata = item_q;
      HEAD_SRC_LINK: head_wdata = link_rd;
      default:       head_wdata = '0;
    endcase
    if (cmd.clr_step) head_wdata = '0;
  end

  // Select link write address and data
  always_comb begin
    case (cmd.link_addr)
      LINK_ADDR_TAIL: link_waddr = tail_rd;
      LINK_ADDR_HEAD: link_waddr = head_rd;
      default:        link_waddr = item_q;
    endcase
    case (cmd.link_src)
      LINK_SRC_ITEM: link_wdata = item_q;
      LINK_SRC_HEAD: link_wdata = head_rd;
      default:       link_wdata = '0;
    endcase
  end

  // Head memory
  always_ff @(posedge clk) begin
    if (head_wen) head_mem[head_waddr] <= head_wdata;
    if (cmd.capture) head_rd <= head_mem[list_sel];
  end

  // Tail memory
  always_ff @(posedge clk) begin
    if (cmd.tail_we) tail_mem[list_q] <= item_q;
    if (cmd.capture) tail_rd <= tail_mem[list_sel];
  end

  // Link memory
  always_ff @(posedge clk) begin
    if (cmd.link_we) link_mem[link_waddr] <= link_wdata;
    if (cmd.link_rd) link_rd <= link_mem[head_rd];
  end

  // Hold the pending result
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_item   <= cmd.res_from_head ? head_rd : '0;
      res_status <= cmd.res_status;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      item_out <= res_item;
      status   <= res_status;
    end
  end

  // Status to the controller
  always_comb begin
    sts.op         = op_q;
    sts.item_bad   = (item_q == '0) || (item_q > MAX_ITEM);
    sts.list_bad   = list_q > MAX_LIST;
    sts.head_empty = (head_rd == '0) || (head_rd > MAX_ITEM);
    sts.tail_ok    = tail_rd <= MAX_ITEM;
    sts.clr_last   = clr_cnt == MAX_LIST;
    sts.out_busy   = out_valid && !out_ready;
  end

  `ASSERT_NEVER(a_out_overrun, cmd.out_load && out_valid && !out_ready, "result overwritten before transfer")
  `ASSERT_NEVER(a_link_range, cmd.link_we && link_waddr > MAX_ITEM, "link write beyond item pool")

endmodule

// ----- rtl/multi_queue_linked_list_core.sv -----
// Multi-queue linked-list core: many singly linked lists over one item pool.
// A request passes the lookup state and, for a successful enqueue or dequeue, a tail-link
// or link-read state, then the result state, which loads the registered output. Requests
// are taken one at a time: a new one is accepted only after the last result is loaded,
// which waits while the response is not taken. Reset: synchronous; a clearing pass then
// zeroes head memory entries 0 to NUM_LISTS, during which no request is taken.
module multi_queue_linked_list_core #(
  parameter int NUM_ITEMS = 1023,
  parameter int NUM_LISTS = 63
) (
  input logic        clk,
  input logic        rst,
  mqll_req_if.sink   req,
  mqll_rsp_if.source rsp
);
  import mqll_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  mqll_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mqll_datapath #(
    .NUM_ITEMS (NUM_ITEMS),
    .NUM_LISTS (NUM_LISTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .op        (req.op),
    .item_in   (req.item_in),
    .list_sel  (req.list_sel),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .item_out  (rsp.item_out),
    .status    (rsp.status)
  );

endmodule
